### rtl/v8dfr_pkg.sv
// Shared constants and types for the asynchronous octet deframer.
// Used by the top level and by the message store; depends on nothing.
`default_nettype none

package v8dfr_pkg;

    // Line window geometry.
    localparam int WIN_W       = 20;
    localparam int NEW_BIT_POS = 19;
    localparam int OCTET_LSB   = 11;

    // Preamble plus sync, and the start/stop framing test on the window.
    localparam logic [WIN_W-1:0] SYNC_PATTERN = 20'hF03FF;
    localparam logic [WIN_W-1:0] FRAME_MASK   = 20'h80400;
    localparam logic [WIN_W-1:0] FRAME_MATCH  = 20'h80000;

    localparam logic [7:0] BYTE_ONES  = 8'hFF;
    localparam logic [7:0] BYTE_ZEROS = 8'h00;

    // Flag periodicity counter saturates here.
    localparam logic [9:0] FLAG_LIMIT = 10'd1000;

    // Bits in one start/stop frame; the bit counter saturates here.
    localparam logic [3:0] FRAME_BITS = 4'd10;
    localparam logic [3:0] BITS_AFTER_SYNC = 4'd1;

    // Zero octets in a row that mark CJ.
    localparam logic [1:0] CJ_RUN = 2'd3;

    // Input command codes.
    localparam logic CMD_PUSH = 1'b0;
    localparam logic CMD_READ = 1'b1;

    // Requests from the framing logic to the message store.
    typedef struct packed {
        logic       pass_start;
        logic       octet_we;
        logic [7:0] octet;
    } store_ctl_t;

    // Status from the message store back to the framing logic.
    typedef struct packed {
        logic pass_done;
        logic pass_match;
    } store_stat_t;

endpackage

`default_nettype wire

### rtl/v8dfr_store.sv
// Message store: current, previous and latched byte memories plus the
// compare-and-copy pass run at each sync. Depends on v8dfr_pkg.
`default_nettype none

module v8dfr_store #(
    parameter int MSG_BYTES = 64,
    localparam int IDX_W = $clog2(MSG_BYTES),
    localparam int LEN_W = $clog2(MSG_BYTES + 1)
) (
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire v8dfr_pkg::store_ctl_t   ctl,
    input  wire logic [IDX_W-1:0]        octet_addr,
    input  wire logic [LEN_W-1:0]        pass_len,
    input  wire logic [IDX_W-1:0]        rd_addr,
    output v8dfr_pkg::store_stat_t       stat,
    output logic [7:0]                   rd_data
);
    import v8dfr_pkg::*;

    logic [7:0] cur_mem  [MSG_BYTES];
    logic [7:0] prev_mem [MSG_BYTES];
    logic [7:0] lat_mem  [MSG_BYTES];

    logic             run_reg;
    logic [LEN_W-1:0] cnt_reg;
    logic [LEN_W-1:0] len_reg;
    logic             vld_reg;
    logic             match_reg;
    logic [IDX_W-1:0] waddr_reg;
    logic [7:0]       cur_rd_reg;
    logic [7:0]       prev_rd_reg;
    logic [7:0]       rd_data_reg;

    logic             issue;
    logic             done;
    logic [IDX_W-1:0] cnt_idx;

    // One byte pair is read per cycle; the compare and the write-back
    // happen in the following cycle from the registered read data.
    assign cnt_idx = cnt_reg[IDX_W-1:0];
    assign issue   = run_reg && (cnt_reg != len_reg);
    assign done    = run_reg && !issue && !vld_reg;

    // Pass sequencer.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg   <= 1'b0;
            cnt_reg   <= '0;
            len_reg   <= '0;
            vld_reg   <= 1'b0;
            match_reg <= 1'b0;
        end
        else if (ctl.pass_start)
        begin
            run_reg   <= 1'b1;
            cnt_reg   <= '0;
            len_reg   <= pass_len;
            vld_reg   <= 1'b0;
            match_reg <= 1'b1;
        end
        else if (run_reg)
        begin
            vld_reg <= issue;
            if (issue)
            begin
                cnt_reg <= cnt_reg + LEN_W'(1);
            end
            if (vld_reg && (cur_rd_reg != prev_rd_reg))
            begin
                match_reg <= 1'b0;
            end
            if (done)
            begin
                run_reg <= 1'b0;
            end
        end
    end

    // Write address of the byte now in the read registers.
    always_ff @(posedge clk)
    begin
        waddr_reg <= cnt_idx;
    end

    // Current reception: filled by framed octets, read by the pass.
    always_ff @(posedge clk)
    begin
        if (ctl.octet_we)
        begin
            cur_mem[octet_addr] <= ctl.octet;
        end
        cur_rd_reg <= cur_mem[cnt_idx];
    end

    // Previous reception: compared and then overwritten by the pass. When
    // the bytes match the overwrite leaves it unchanged.
    always_ff @(posedge clk)
    begin
        if (vld_reg)
        begin
            prev_mem[waddr_reg] <= cur_rd_reg;
        end
        prev_rd_reg <= prev_mem[cnt_idx];
    end

    // Latched message: written by every pass, but only read once the
    // latched flag is set, after which no pass runs.
    always_ff @(posedge clk)
    begin
        if (vld_reg)
        begin
            lat_mem[waddr_reg] <= cur_rd_reg;
        end
        rd_data_reg <= lat_mem[rd_addr];
    end

    assign stat.pass_done  = done;
    assign stat.pass_match = match_reg;
    assign rd_data         = rd_data_reg;

endmodule

`default_nettype wire

### rtl/v8_async_octet_deframer.sv
// Asynchronous octet deframer top level: bit window, flag counter, sync
// and start/stop framing, CJ detection and the handshake. Depends on
// v8dfr_pkg and v8dfr_store.
//
// Each input word either pushes one line bit (cmd 0) or reads one byte of
// the latched message (cmd 1), and every input word yields exactly one
// output word. A bit push that is not a sync has its result registered
// straight from the idle state, while a read first passes through the
// read state because the latched byte comes from a memory with a
// registered read port. A sync seen before a message is latched starts a
// pass over the bytes gathered since the previous sync: one byte per
// cycle is read from the current and previous stores, compared in a
// single byte comparator, and written back to the previous and latched
// stores, and the result word is given when the pass is done. The block
// takes no input while a word is in work or while its result waits to be
// taken; the status outputs show the state after the word on the output
// channel.
`default_nettype none

module v8_async_octet_deframer #(
    parameter int MSG_BYTES = 64,
    localparam int IDX_W = $clog2(MSG_BYTES),
    localparam int LEN_W = $clog2(MSG_BYTES + 1)
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             in_valid,
    output logic                  in_ready,
    input  wire logic             cmd,
    input  wire logic             rx_bit,
    input  wire logic [5:0]       read_index,
    output logic                  out_valid,
    input  wire logic             out_ready,
    output logic                  octet_strobe,
    output logic [7:0]            octet_value,
    output logic                  sync_seen,
    output logic                  message_valid,
    output logic [LEN_W-1:0]      message_length,
    output logic                  cj_seen,
    output logic [9:0]            flag_run,
    output logic [7:0]            read_byte
);
    import v8dfr_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_READ,
        ST_PASS
    } state_t;

    state_t           state_reg,     state_next;
    logic [WIN_W-1:0] win_reg,       win_next;
    logic [9:0]       flag_cnt_reg,  flag_cnt_next;
    logic             synced_reg,    synced_next;
    logic [3:0]       bits_reg,      bits_next;
    logic [LEN_W-1:0] cur_len_reg,   cur_len_next;
    logic [LEN_W-1:0] prev_len_reg,  prev_len_next;
    logic [LEN_W-1:0] lat_len_reg,   lat_len_next;
    logic             lat_flag_reg,  lat_flag_next;
    logic [1:0]       zrun_reg,      zrun_next;
    logic             cj_reg,        cj_next;
    logic             len_eq_reg,    len_eq_next;
    logic             read_ok_reg,   read_ok_next;
    logic             out_valid_reg, out_valid_next;
    logic             strobe_reg,    strobe_next;
    logic [7:0]       value_reg,     value_next;
    logic [7:0]       rbyte_reg,     rbyte_next;

    logic             accept;
    logic [WIN_W-1:0] win_new;
    logic [7:0]       win_lo;
    logic             flag_hit;
    logic             is_sync;
    logic [3:0]       bits_inc;
    logic             frame_hit;
    logic [7:0]       octet;
    logic             store_ok;
    logic [1:0]       zrun_inc;
    logic [LEN_W+5:0] idx_wide;
    logic [LEN_W+5:0] len_wide;
    logic [IDX_W+5:0] addr_wide;
    logic [IDX_W-1:0] rd_addr;

    store_ctl_t       ctl;
    store_stat_t      stat;
    logic [7:0]       rd_data;

    // Handshake: one word at a time, and only when the output is free.
    assign in_ready = (state_reg == ST_IDLE) && (!out_valid_reg || out_ready);
    assign accept   = in_valid && in_ready;

    // Bit window and the tests made on it.
    assign win_new   = {rx_bit, win_reg[NEW_BIT_POS:1]};
    assign win_lo    = win_new[7:0];
    assign flag_hit  = (win_lo == win_new[15:8]) && (win_lo != BYTE_ZEROS)
                       && (win_lo != BYTE_ONES);
    assign is_sync   = (win_new == SYNC_PATTERN);
    assign bits_inc  = (bits_reg < FRAME_BITS) ? bits_reg + 4'd1 : bits_reg;
    assign frame_hit = ((win_new & FRAME_MASK) == FRAME_MATCH)
                       && (bits_inc >= FRAME_BITS);
    assign octet     = win_new[OCTET_LSB +: 8];
    assign store_ok  = (cur_len_reg < LEN_W'(MSG_BYTES));
    assign zrun_inc  = (zrun_reg < CJ_RUN) ? zrun_reg + 2'd1 : zrun_reg;

    // Read index against the latched length, and the store address.
    assign idx_wide  = {{LEN_W{1'b0}}, read_index};
    assign len_wide  = {6'd0, lat_len_reg};
    assign addr_wide = {{IDX_W{1'b0}}, read_index};
    assign rd_addr   = addr_wide[IDX_W-1:0];

    // Next-state logic for the sequencer and all step state.
    always_comb
    begin
        state_next     = state_reg;
        win_next       = win_reg;
        flag_cnt_next  = flag_cnt_reg;
        synced_next    = synced_reg;
        bits_next      = bits_reg;
        cur_len_next   = cur_len_reg;
        prev_len_next  = prev_len_reg;
        lat_len_next   = lat_len_reg;
        lat_flag_next  = lat_flag_reg;
        zrun_next      = zrun_reg;
        cj_next        = cj_reg;
        len_eq_next    = len_eq_reg;
        read_ok_next   = read_ok_reg;
        out_valid_next = out_valid_reg && !out_ready;
        strobe_next    = strobe_reg;
        value_next     = value_reg;
        rbyte_next     = rbyte_reg;
        ctl            = '0;
        ctl.octet      = octet;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (cmd == CMD_READ)
                    begin
                        read_ok_next = lat_flag_reg && (idx_wide < len_wide);
                        state_next   = ST_READ;
                    end
                    else
                    begin
                        win_next      = win_new;
                        flag_cnt_next = !flag_hit ? 10'd0 :
                                        (flag_cnt_reg < FLAG_LIMIT) ?
                                        flag_cnt_reg + 10'd1 : flag_cnt_reg;
                        strobe_next   = 1'b0;
                        value_next    = 8'd0;
                        rbyte_next    = 8'd0;
                        if (is_sync)
                        begin
                            // Sync restarts framing; the sync bit itself counts.
                            synced_next  = 1'b1;
                            bits_next    = BITS_AFTER_SYNC;
                            cur_len_next = '0;
                            if (!lat_flag_reg)
                            begin
                                ctl.pass_start = 1'b1;
                                len_eq_next    = (prev_len_reg != '0)
                                                 && (prev_len_reg == cur_len_reg);
                                prev_len_next  = cur_len_reg;
                                state_next     = ST_PASS;
                            end
                            else
                            begin
                                out_valid_next = 1'b1;
                            end
                        end
                        else
                        begin
                            if (synced_reg)
                            begin
                                bits_next = bits_inc;
                                if (frame_hit)
                                begin
                                    bits_next   = 4'd0;
                                    strobe_next = 1'b1;
                                    value_next  = octet;
                                    if (store_ok)
                                    begin
                                        ctl.octet_we = 1'b1;
                                        cur_len_next = cur_len_reg + LEN_W'(1);
                                    end
                                    if (octet == BYTE_ZEROS)
                                    begin
                                        zrun_next = zrun_inc;
                                        cj_next   = cj_reg || (zrun_inc == CJ_RUN);
                                    end
                                    else
                                    begin
                                        zrun_next = 2'd0;
                                    end
                                end
                            end
                            out_valid_next = 1'b1;
                        end
                    end
                end
            end

            ST_READ:
            begin
                strobe_next    = 1'b0;
                value_next     = 8'd0;
                rbyte_next     = read_ok_reg ? rd_data : 8'd0;
                out_valid_next = 1'b1;
                state_next     = ST_IDLE;
            end

            ST_PASS:
            begin
                if (stat.pass_done)
                begin
                    if (len_eq_reg && stat.pass_match)
                    begin
                        lat_flag_next = 1'b1;
                        lat_len_next  = prev_len_reg;
                    end
                    strobe_next    = 1'b0;
                    value_next     = 8'd0;
                    rbyte_next     = 8'd0;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // State and registered outputs.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            win_reg       <= '0;
            flag_cnt_reg  <= '0;
            synced_reg    <= 1'b0;
            bits_reg      <= '0;
            cur_len_reg   <= '0;
            prev_len_reg  <= '0;
            lat_len_reg   <= '0;
            lat_flag_reg  <= 1'b0;
            zrun_reg      <= '0;
            cj_reg        <= 1'b0;
            len_eq_reg    <= 1'b0;
            read_ok_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
            strobe_reg    <= 1'b0;
            value_reg     <= '0;
            rbyte_reg     <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            win_reg       <= win_next;
            flag_cnt_reg  <= flag_cnt_next;
            synced_reg    <= synced_next;
            bits_reg      <= bits_next;
            cur_len_reg   <= cur_len_next;
            prev_len_reg  <= prev_len_next;
            lat_len_reg   <= lat_len_next;
            lat_flag_reg  <= lat_flag_next;
            zrun_reg      <= zrun_next;
            cj_reg        <= cj_next;
            len_eq_reg    <= len_eq_next;
            read_ok_reg   <= read_ok_next;
            out_valid_reg <= out_valid_next;
            strobe_reg    <= strobe_next;
            value_reg     <= value_next;
            rbyte_reg     <= rbyte_next;
        end
    end

    // Byte memories and the compare-and-copy pass.
    v8dfr_store #(
        .MSG_BYTES (MSG_BYTES)
    ) u_store (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctl        (ctl),
        .octet_addr (cur_len_reg[IDX_W-1:0]),
        .pass_len   (cur_len_reg),
        .rd_addr    (rd_addr),
        .stat       (stat),
        .rd_data    (rd_data)
    );

    // Output channel.
    assign out_valid      = out_valid_reg;
    assign octet_strobe   = strobe_reg;
    assign octet_value    = value_reg;
    assign sync_seen      = synced_reg;
    assign message_valid  = lat_flag_reg;
    assign message_length = lat_len_reg;
    assign cj_seen        = cj_reg;
    assign flag_run       = flag_cnt_reg;
    assign read_byte      = rbyte_reg;

endmodule

`default_nettype wire

### rtl/v8dfr_checker.sv
// Port-level checks for the octet deframer and the bind that attaches
// them to the top level. Depends on v8_async_octet_deframer.
`default_nettype none

module v8dfr_checker (
    input wire logic clk,
    input wire logic rst_n,
    input wire logic in_ready,
    input wire logic out_valid,
    input wire logic out_ready,
    input wire logic octet_strobe,
    input wire logic sync_seen,
    input wire logic message_valid,
    input wire logic cj_seen
);

    // A pending output word is held until it is taken.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> out_valid)
        else $error("output word dropped before it was taken");

    // No new input word is taken while the output is blocked.
    a_no_accept_blocked: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |-> !in_ready)
        else $error("input taken while output word is blocked");

    // A latched message stays latched.
    a_msg_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        message_valid |=> message_valid)
        else $error("message_valid fell without reset");

    // The CJ indication is sticky.
    a_cj_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        cj_seen |=> cj_seen)
        else $error("cj_seen fell without reset");

    // Octets are only framed after a sync.
    a_octet_synced: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && octet_strobe) |-> sync_seen)
        else $error("octet framed before any sync");

endmodule

bind v8_async_octet_deframer v8dfr_checker u_v8dfr_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_ready      (in_ready),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .octet_strobe  (octet_strobe),
    .sync_seen     (sync_seen),
    .message_valid (message_valid),
    .cj_seen       (cj_seen)
);

`default_nettype wire

### verif/tb_v8_async_octet_deframer.sv
// Testbench for the asynchronous octet deframer: drives line bits and read words,
// predicts every result word in a scoreboard class and checks them field by field.
// Depends on v8dfr_pkg and the v8_async_octet_deframer top level.
module tb_v8_async_octet_deframer;
    timeunit 1ns;
    timeprecision 1ps;

    import v8dfr_pkg::*;

    localparam int MSG_BYTES   = 64;
    localparam int WORD_TARGET = 1400;
    localparam int HOLD_CYCLES = 400;
    localparam int CYCLE_LIMIT = 1000000;

    // One result word as it appears on the output ports.
    typedef struct packed {
        logic       strobe;
        logic [7:0] value;
        logic       sync;
        logic       valid;
        logic [6:0] length;
        logic       cj;
        logic [9:0] flags;
        logic [7:0] rbyte;
    } deframer_word_t;

    // Bit-exact copy of the deframer state, and the queue of words still owed.
    class deframer_scoreboard;
        logic [WIN_W-1:0] window;
        logic [9:0]       flag_cnt;
        logic             got_sync;
        logic [3:0]       bit_cnt;
        logic [7:0]       rx_store[MSG_BYTES];
        logic [7:0]       prior_store[MSG_BYTES];
        logic [7:0]       valid_store[MSG_BYTES];
        logic [6:0]       rx_len;
        logic [6:0]       prior_len;
        logic [6:0]       kept_len;
        logic             msg_latched;
        logic [1:0]       zero_cnt;
        logic             cj_flag;
        deframer_word_t   expected_words[$];
        int               errors;

        function new();
            window      = '0;
            flag_cnt    = '0;
            got_sync    = 1'b0;
            bit_cnt     = '0;
            rx_len      = '0;
            prior_len   = '0;
            kept_len    = '0;
            msg_latched = 1'b0;
            zero_cnt    = '0;
            cj_flag     = 1'b0;
            errors      = 0;
            foreach (rx_store[i])
            begin
                rx_store[i]    = '0;
                prior_store[i] = '0;
                valid_store[i] = '0;
            end
        endfunction

        function int pending();
            return expected_words.size();
        endfunction

        // At a sync the gathered reception is compared with the one before it.
        function void take_sync();
            logic equal;
            int   i;
            if (!msg_latched)
            begin
                equal = (prior_len != 0) && (prior_len == rx_len);
                for (i = 0; i < rx_len; i++)
                    if (prior_store[i] != rx_store[i])
                        equal = 1'b0;
                if (equal)
                begin
                    for (i = 0; i < rx_len; i++)
                        valid_store[i] = rx_store[i];
                    kept_len    = rx_len;
                    msg_latched = 1'b1;
                end
                else
                begin
                    for (i = 0; i < rx_len; i++)
                        prior_store[i] = rx_store[i];
                    prior_len = rx_len;
                end
            end
            got_sync = 1'b1;
            bit_cnt  = '0;
            rx_len   = '0;
        endfunction

        // Advance the state by one accepted input word and queue its result.
        function void note_word(logic c, logic b, logic [5:0] idx);
            deframer_word_t   r;
            logic [WIN_W-1:0] w;
            logic [7:0]       octet;
            r = '0;
            if (c == CMD_PUSH)
            begin
                w      = {b, window[WIN_W-1:1]};
                window = w;
                if (w[7:0] == w[15:8] && w[7:0] != BYTE_ZEROS && w[7:0] != BYTE_ONES)
                begin
                    if (flag_cnt < FLAG_LIMIT)
                        flag_cnt++;
                end
                else
                    flag_cnt = '0;
                if (w == SYNC_PATTERN)
                    take_sync();
                if (got_sync)
                begin
                    if (bit_cnt < FRAME_BITS)
                        bit_cnt++;
                    if ((w & FRAME_MASK) == FRAME_MATCH && bit_cnt >= FRAME_BITS)
                    begin
                        octet = w[OCTET_LSB +: 8];
                        if (rx_len < MSG_BYTES)
                        begin
                            rx_store[rx_len] = octet;
                            rx_len++;
                        end
                        if (octet == BYTE_ZEROS)
                        begin
                            if (zero_cnt < CJ_RUN)
                                zero_cnt++;
                            if (zero_cnt >= CJ_RUN)
                                cj_flag = 1'b1;
                        end
                        else
                            zero_cnt = '0;
                        bit_cnt  = '0;
                        r.strobe = 1'b1;
                        r.value  = octet;
                    end
                end
            end
            else if (msg_latched && idx < kept_len)
                r.rbyte = valid_store[idx];
            r.sync   = got_sync;
            r.valid  = msg_latched;
            r.length = kept_len;
            r.cj     = cj_flag;
            r.flags  = flag_cnt;
            expected_words.push_back(r);
        endfunction

        function void check_field(string name, logic [9:0] exp_v, logic [9:0] act_v);
            if (act_v !== exp_v)
            begin
                $error("%s: expected %0h, actual %0h", name, exp_v, act_v);
                errors++;
            end
        endfunction

        // Compare one accepted result word with the oldest expected word.
        function void check_word(deframer_word_t act);
            deframer_word_t exp_w;
            if (expected_words.size() == 0)
            begin
                $error("result word with no expected word waiting");
                errors++;
                return;
            end
            exp_w = expected_words.pop_front();
            check_field("octet_strobe", exp_w.strobe, act.strobe);
            check_field("octet_value", exp_w.value, act.value);
            check_field("sync_seen", exp_w.sync, act.sync);
            check_field("message_valid", exp_w.valid, act.valid);
            check_field("message_length", exp_w.length, act.length);
            check_field("cj_seen", exp_w.cj, act.cj);
            check_field("flag_run", exp_w.flags, act.flags);
            check_field("read_byte", exp_w.rbyte, act.rbyte);
        endfunction
    endclass

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       in_valid = 1'b0;
    logic       in_ready;
    logic       cmd = CMD_PUSH;
    logic       rx_bit = 1'b0;
    logic [5:0] read_index = '0;
    logic       out_valid;
    logic       out_ready = 1'b0;
    logic       octet_strobe;
    logic [7:0] octet_value;
    logic       sync_seen;
    logic       message_valid;
    logic [6:0] message_length;
    logic       cj_seen;
    logic [9:0] flag_run;
    logic [7:0] read_byte;

    deframer_scoreboard sb = new();
    deframer_word_t     seen_word;
    int                 words_sent = 0;
    int                 burst_left = 0;
    int                 cycle_cnt = 0;
    bit                 hold_off_req = 1'b0;

    v8_async_octet_deframer uut (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_ready(in_ready),
        .cmd(cmd),
        .rx_bit(rx_bit),
        .read_index(read_index),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .octet_strobe(octet_strobe),
        .octet_value(octet_value),
        .sync_seen(sync_seen),
        .message_valid(message_valid),
        .message_length(message_length),
        .cj_seen(cj_seen),
        .flag_run(flag_run),
        .read_byte(read_byte)
    );

    // 20 ns clock.
    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // Run limit.
    always @(posedge clk)
    begin
        cycle_cnt++;
        if (cycle_cnt > CYCLE_LIMIT)
        begin
            $display("Some tests failed");
            $finish;
        end
    end

    // Result monitor: every accepted output word goes to the scoreboard.
    always @(posedge clk)
    begin
        if (out_valid && out_ready)
        begin
            seen_word = {octet_strobe, octet_value, sync_seen, message_valid,
                         message_length, cj_seen, flag_run, read_byte};
            sb.check_word(seen_word);
        end
    end

    // Receiver: segments of different stall patterns, plus one long hold-off
    // when the stimulus asks for it.
    initial
    begin : receiver
        int mode;
        int seg_left;
        int hold_left;
        mode      = 0;
        seg_left  = 0;
        hold_left = 0;
        forever
        begin
            @(posedge clk);
            if (hold_off_req)
            begin
                hold_off_req = 1'b0;
                hold_left    = HOLD_CYCLES;
            end
            if (seg_left == 0)
            begin
                mode     = $urandom_range(0, 3);
                seg_left = $urandom_range(20, 300);
            end
            seg_left--;
            if (hold_left > 0)
            begin
                hold_left--;
                out_ready <= 1'b0;
            end
            else
            begin
                case (mode)
                    0: out_ready <= 1'b1;
                    1: out_ready <= 1'($urandom_range(0, 1));
                    2: out_ready <= ($urandom_range(0, 3) == 0);
                    default: out_ready <= (seg_left % 5 != 0);
                endcase
            end
        end
    end

    // Offer one input word and wait until it is taken; bursts with random gaps.
    task automatic send_word(input logic c, input logic b, input logic [5:0] idx);
        int gap;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            if (gap > 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = $urandom_range(1, 48);
        end
        burst_left--;
        in_valid   <= 1'b1;
        cmd        <= c;
        rx_bit     <= b;
        read_index <= idx;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        sb.note_word(c, b, idx);
        words_sent++;
    endtask

    task automatic push_line_bit(input logic b);
        send_word(CMD_PUSH, b, 6'($urandom));
    endtask

    task automatic read_message_byte(input logic [5:0] idx);
        send_word(CMD_READ, 1'($urandom), idx);
    endtask

    // Sender pause until every expected word has come back.
    task automatic wait_for_drain();
        in_valid <= 1'b0;
        do
            @(posedge clk);
        while (sb.pending() != 0);
    endtask

    task automatic push_marks(input int n);
        repeat (n) push_line_bit(1'b1);
    endtask

    // Preamble plus sync: ten ones, six zeros, four ones.
    task automatic push_sync();
        push_marks(10);
        repeat (6) push_line_bit(1'b0);
        push_marks(4);
    endtask

    // Start bit, eight data bits LSB first, stop bit.
    task automatic push_octet(input logic [7:0] v);
        int i;
        push_line_bit(1'b0);
        for (i = 0; i < 8; i++)
            push_line_bit(v[i]);
        push_line_bit(1'b1);
    endtask

    // An 8-periodic run built from one flag-like byte.
    task automatic push_flags(input logic [7:0] f, input int n);
        int i;
        for (i = 0; i < n; i++)
            push_line_bit(f[i % 8]);
    endtask

    task automatic push_noise(input int n);
        repeat (n)
        begin
            if ($urandom_range(0, 9) == 0)
                read_message_byte(6'($urandom));
            else
                push_line_bit(1'($urandom));
        end
    endtask

    function automatic logic [7:0] pick_octet();
        return ($urandom_range(0, 9) == 0) ? BYTE_ZEROS : 8'($urandom);
    endfunction

    function automatic logic [7:0] pick_flag_byte();
        logic [7:0] v;
        do
            v = 8'($urandom);
        while (v == BYTE_ZEROS || v == BYTE_ONES);
        return v;
    endfunction

    function automatic void make_message(output logic [7:0] m[$], input int n);
        m = {};
        repeat (n) m.push_back(pick_octet());
    endfunction

    // Sync followed by framed octets, with idle marks and stray reads between.
    task automatic send_reception(input logic [7:0] m[$], input int max_marks,
                                  input bit with_reads);
        int i;
        push_sync();
        for (i = 0; i < m.size(); i++)
        begin
            if (with_reads && $urandom_range(0, 7) == 0)
                read_message_byte(6'($urandom));
            push_marks($urandom_range(0, max_marks));
            push_octet(m[i]);
        end
    endtask

    initial
    begin : stimulus
        logic [7:0] msg[$];
        logic [7:0] alt[$];
        int         i;
        int         k;
        int         pick;

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reads with nothing latched, and a framed octet before any sync.
        read_message_byte(6'd0);
        read_message_byte(6'd63);
        push_octet(8'hA5);
        push_line_bit(1'b0);
        push_line_bit(1'b1);

        // Empty receptions never latch.
        push_sync();
        push_marks(3);
        push_sync();
        push_sync();
        push_noise(30);

        // A reception longer than the store; the extra octets are still framed.
        make_message(msg, MSG_BYTES + 1);
        send_reception(msg, 0, 0);
        push_sync();
        wait_for_drain();

        // Flag run while the receiver holds off, so the input stalls.
        hold_off_req = 1'b1;
        push_flags(8'h7E, 100);
        wait_for_drain();

        // Pairs that differ, so nothing latches yet.
        for (k = 0; k < 2; k++)
        begin
            make_message(msg, $urandom_range(1, 4));
            send_reception(msg, 2, 1);
            alt = msg;
            if ($urandom_range(0, 1) == 1)
                alt[$urandom_range(0, alt.size() - 1)] ^= 8'($urandom_range(1, 255));
            else
                alt.push_back(pick_octet());
            send_reception(alt, 2, 1);
        end

        // Two identical receptions latch the message at the next sync.
        make_message(msg, $urandom_range(4, 8));
        send_reception(msg, 0, 0);
        send_reception(msg, 0, 0);
        push_sync();
        wait_for_drain();

        // Every index, in range and past the latched length.
        for (i = 0; i < MSG_BYTES; i++)
            read_message_byte(6'(i));

        // Three zero octets in a row mark CJ.
        repeat (3) push_octet(BYTE_ZEROS);
        push_octet(8'($urandom_range(1, 255)));

        // Mixed traffic until the word budget is used.
        while (words_sent < WORD_TARGET)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 30)
            begin
                make_message(msg, $urandom_range(0, 12));
                send_reception(msg, 2, 1);
            end
            else if (pick < 45)
                send_reception(msg, 2, 1);
            else if (pick < 60)
                push_noise($urandom_range(1, 30));
            else if (pick < 75)
                repeat ($urandom_range(1, 6)) read_message_byte(6'($urandom));
            else if (pick < 85)
                push_flags(pick_flag_byte(), $urandom_range(8, 80));
            else if (pick < 95)
            begin
                repeat ($urandom_range(1, 3)) push_octet(BYTE_ZEROS);
                push_octet(8'($urandom_range(1, 255)));
            end
            else
                wait_for_drain();
        end

        // Let the last results come back, then a margin for a sync pass.
        wait_for_drain();
        repeat (MSG_BYTES + 8) @(posedge clk);
        if (sb.errors == 0 && sb.pending() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end
endmodule

### sim.f
rtl/v8dfr_pkg.sv
rtl/v8dfr_store.sv
rtl/v8_async_octet_deframer.sv
rtl/v8dfr_checker.sv
verif/tb_v8_async_octet_deframer.sv
